// ===== hw/rtl/kfd_pkg.sv =====
package kfd_pkg;

    // KISS special characters
    localparam logic [7:0] KS_FEND   = 8'hC0;
    localparam logic [7:0] KS_FESC   = 8'hDB;
    localparam logic [7:0] KS_TFEND  = 8'hDC;
    localparam logic [7:0] KS_TFESC  = 8'hDD;
    localparam logic [7:0] KS_NIBBLE = 8'h0F;

    // Frame size limit, command byte included
    localparam int MAX_FRAME = 1024;
    localparam int CNT_W     = 11;

    // Result queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One result word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_marker;
        logic       frame_ok;
    } kfd_entry_t;

    // Write side of the queue
    typedef struct packed {
        logic       valid;
        kfd_entry_t entry;
    } kfd_push_t;

    // Queue status
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } kfd_qstat_t;

endpackage

// ===== hw/rtl/kiss_frame_deframer_unit.sv =====
// KISS deframer: takes one raw serial byte per word on the s_ channel
// (s_valid/s_ready, s_rx_byte) and streams decoded payload words on the m_
// channel (m_valid/m_ready). A frame whose command low nibble matches the
// accepted type is forwarded byte by byte, then closed by an end marker if it had payload:
// frame_ok set on a closing FEND, clear when the frame overran MAX_FRAME.
// The accepted type is written through cfg_valid/cfg_ready/cfg_accepted_type
// (cfg_ready is always high); write it only while the block is idle.
// Throughput is one byte per cycle while the queue is not full. A result
// reaches m_ via the queue: the front decodes the byte and writes it into
// the 4-word queue when taken, and the output register loads it when free.
// Bytes that yield no result leave no trace on the m_ side.
// When m_ready is low the output register holds its word and the queue
// fills; s_ready drops only while the queue is full, so the front keeps
// taking bytes until four more results wait behind the held word.
// Synchronous active-low reset clears the frame state (idle, no escape,
// count zero), empties the queue and output, and sets the accepted type to 0.
module kiss_frame_deframer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_accepted_type,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_payload_byte,
    output logic       m_end_marker,
    output logic       m_frame_ok
);

    kfd_pkg::kfd_push_t  q_push;
    kfd_pkg::kfd_entry_t q_head;
    kfd_pkg::kfd_qstat_t q_stat;
    logic                q_pop;

    kfd_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_accepted_type (cfg_accepted_type),
        .q_stat            (q_stat),
        .q_push            (q_push)
    );

    kfd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_stat  (q_stat)
    );

    kfd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_head         (q_head),
        .q_stat         (q_stat),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_end_marker   (m_end_marker),
        .m_frame_ok     (m_frame_ok)
    );

    // Front never writes a word into a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push.valid |-> !q_stat.full)
        else $error("push into full queue");

    // Occupancy stays within the queue depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= kfd_pkg::Q_CNT_W'(kfd_pkg::Q_DEPTH))
        else $error("queue count out of range");

    // Payload words never carry frame_ok
    a_payload_no_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_end_marker) |-> !m_frame_ok)
        else $error("frame_ok on payload word");

    // End markers carry a zero byte
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_marker) |-> (m_payload_byte == 8'd0))
        else $error("nonzero byte on end marker");

endmodule

// ===== hw/rtl/kfd_front.sv =====
module kfd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_accepted_type,
    input  kfd_pkg::kfd_qstat_t q_stat,
    output kfd_pkg::kfd_push_t q_push
);

    logic                     inside_frame_reg, inside_frame_next;
    logic                     escape_pending_reg, escape_pending_next;
    logic                     type_matches_reg, type_matches_next;
    logic [kfd_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [3:0]               accepted_type_reg;
    logic                     take;
    logic [7:0]               dec_byte;
    logic                     do_store;
    kfd_pkg::kfd_push_t       push_c;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_stat.full;
    assign take      = s_valid && s_ready;

    // Hold the configured frame type
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepted_type_reg <= 4'd0;
        end else if (cfg_valid && cfg_ready) begin
            accepted_type_reg <= cfg_accepted_type;
        end
    end

    // Undo the escape on the byte that follows FESC
    always_comb begin
        dec_byte = s_rx_byte;
        if (escape_pending_reg) begin
            if (s_rx_byte == kfd_pkg::KS_TFEND) begin
                dec_byte = kfd_pkg::KS_FEND;
            end else if (s_rx_byte == kfd_pkg::KS_TFESC) begin
                dec_byte = kfd_pkg::KS_FESC;
            end
        end
    end

    // Classify the word and advance the frame state
    always_comb begin
        inside_frame_next   = inside_frame_reg;
        escape_pending_next = escape_pending_reg;
        type_matches_next   = type_matches_reg;
        byte_count_next     = byte_count_reg;
        do_store            = 1'b0;
        push_c              = '0;

        if (take) begin
            if (s_rx_byte == kfd_pkg::KS_FEND) begin
                push_c.valid            = inside_frame_reg && type_matches_reg
                                          && (byte_count_reg > kfd_pkg::CNT_W'(1));
                push_c.entry.end_marker = 1'b1;
                push_c.entry.frame_ok   = 1'b1;
                inside_frame_next       = 1'b1;
                escape_pending_next     = 1'b0;
                type_matches_next       = 1'b0;
                byte_count_next         = '0;
            end else if (inside_frame_reg) begin
                if (escape_pending_reg) begin
                    escape_pending_next = 1'b0;
                    do_store            = 1'b1;
                end else if (s_rx_byte == kfd_pkg::KS_FESC) begin
                    escape_pending_next = 1'b1;
                end else begin
                    do_store = 1'b1;
                end
            end

            if (do_store) begin
                if (byte_count_reg < kfd_pkg::CNT_W'(kfd_pkg::MAX_FRAME)) begin
                    if (byte_count_reg == '0) begin
                        type_matches_next = ((dec_byte & kfd_pkg::KS_NIBBLE)
                                             == {4'd0, accepted_type_reg});
                    end else if (type_matches_reg) begin
                        push_c.valid              = 1'b1;
                        push_c.entry.payload_byte = dec_byte;
                    end
                    byte_count_next = byte_count_reg + kfd_pkg::CNT_W'(1);
                end else begin
                    // Overflow: abort the frame and drop to idle
                    push_c.valid            = type_matches_reg;
                    push_c.entry.end_marker = 1'b1;
                    push_c.entry.frame_ok   = 1'b0;
                    inside_frame_next       = 1'b0;
                    type_matches_next       = 1'b0;
                    byte_count_next         = '0;
                end
            end
        end
    end

    assign q_push = push_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_frame_reg   <= 1'b0;
            escape_pending_reg <= 1'b0;
            type_matches_reg   <= 1'b0;
            byte_count_reg     <= '0;
        end else begin
            inside_frame_reg   <= inside_frame_next;
            escape_pending_reg <= escape_pending_next;
            type_matches_reg   <= type_matches_next;
            byte_count_reg     <= byte_count_next;
        end
    end

endmodule

// ===== hw/rtl/kfd_queue.sv =====
module kfd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  kfd_pkg::kfd_push_t  q_push,
    input  logic                q_pop,
    output kfd_pkg::kfd_entry_t q_head,
    output kfd_pkg::kfd_qstat_t q_stat
);

    kfd_pkg::kfd_entry_t          q_mem_reg [kfd_pkg::Q_DEPTH];
    logic [kfd_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [kfd_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [kfd_pkg::Q_CNT_W-1:0]  count_reg, count_next;
    logic                         do_push, do_pop;

    assign q_stat.full  = (count_reg == kfd_pkg::Q_CNT_W'(kfd_pkg::Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.count = count_reg;
    assign q_head       = q_mem_reg[rd_ptr_reg];

    assign do_push = q_push.valid && !q_stat.full;
    assign do_pop  = q_pop && !q_stat.empty;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + kfd_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + kfd_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + kfd_pkg::Q_CNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - kfd_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

// ===== hw/rtl/kfd_back.sv =====
module kfd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  kfd_pkg::kfd_entry_t q_head,
    input  kfd_pkg::kfd_qstat_t q_stat,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_payload_byte,
    output logic                m_end_marker,
    output logic                m_frame_ok
);

    logic                m_valid_reg, m_valid_next;
    kfd_pkg::kfd_entry_t out_reg;

    // Load the output register when it is empty or being taken
    assign q_pop        = !q_stat.empty && (!m_valid_reg || m_ready);
    assign m_valid_next = q_pop || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_head;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_end_marker   = out_reg.end_marker;
    assign m_frame_ok     = out_reg.frame_ok;

endmodule
